// ----- src/wsg_pkg.sv -----
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the waveform sample generator
// Field widths, register codes, shape codes and the Q1.15 saturation helper.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int SINE_ENTRIES = 1024;
  localparam int COUNT_MAX    = 4095;

  // Field widths
  localparam int IDX_W      = 32;
  localparam int PHASE_W    = 32;
  localparam int ADC_W      = 12;
  localparam int Q15_W      = 16;
  localparam int OFFSET_W   = 17;
  localparam int SHAPE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Edge divider: numerator 2n+D, divisor 2D, quotient at most 65536
  localparam int DEN_W  = 16;
  localparam int NUM_W  = 34;
  localparam int QUOT_W = 17;
  localparam logic [QUOT_W-1:0] QUOT_MAX = 17'h10000;

  localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [Q15_W-1:0] Q15_MIN = -16'sh8000;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SHAPE    = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_PHASE_START   = 3'd2,
    REG_DUTY_POINT    = 3'd3,
    REG_EDGE_WIDTH    = 3'd4,
    REG_GAIN_COUNTS   = 3'd5,
    REG_OFFSET_COUNTS = 3'd6
  } cfg_reg_e;

  // Wave shape codes; codes above flat also give a flat zero
  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_SQUARE   = 3'd1,
    SHAPE_TRIANGLE = 3'd2,
    SHAPE_RAMP     = 3'd3,
    SHAPE_FLAT     = 3'd4
  } shape_e;

  // How the wave value of an item is finally formed
  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_SINE  = 2'd1,
    KIND_DIV   = 2'd2
  } kind_e;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    kind_e                    kind;
    logic                     neg;   // falling edge: 32768 - q, else q - 32768
    logic signed [Q15_W-1:0]  w;     // constant or sine value
  } side_t;

  // Configuration register bank
  typedef struct packed {
    logic [SHAPE_W-1:0]          wave_shape;
    logic [PHASE_W-1:0]          phase_step;
    logic [PHASE_W-1:0]          phase_start;
    logic [DEN_W-1:0]            duty_point;
    logic [DEN_W-1:0]            edge_width;
    logic [DEN_W-1:0]            gain_counts;
    logic signed [OFFSET_W-1:0]  offset_counts;
  } cfg_t;

  // Saturate a 19-bit intermediate to Q1.15
  function automatic logic signed [Q15_W-1:0] sat_q15(input logic signed [18:0] v);
    logic signed [Q15_W-1:0] r;
    if (v > 19'sd32767) begin
      r = Q15_MAX;
    end else if (v < -19'sd32768) begin
      r = Q15_MIN;
    end else begin
      r = v[Q15_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/wsg_in_if.sv -----
// ----------------------------------------------------------------------------
// wsg_in_if: sample index stream
// Valid/ready channel that carries one sample index per transfer.
// ----------------------------------------------------------------------------
interface wsg_in_if;
  import wsg_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

// ----- src/wsg_out_if.sv -----
// ----------------------------------------------------------------------------
// wsg_out_if: sample code stream
// Valid/ready channel that carries one 12-bit ADC code per transfer.
// ----------------------------------------------------------------------------
interface wsg_out_if;
  import wsg_pkg::*;

  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_counts;

  modport source (output valid, output adc_counts, input ready);
  modport sink   (input valid, input adc_counts, output ready);
endinterface

// ----- src/wsg_phase.sv -----
// ----------------------------------------------------------------------------
// wsg_phase: phase accumulator stages
// Two stages: index times step, then plus the start phase, modulo 2^32.
// ----------------------------------------------------------------------------
module wsg_phase (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsg_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wsg_pkg::IDX_W-1:0]     in_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsg_pkg::PHASE_W-1:0]   out_phase_o
);
  import wsg_pkg::*;

  logic               v0_q, v1_q;
  logic               rdy0, rdy1;
  logic [PHASE_W-1:0] prod_d, prod_q;
  logic [PHASE_W-1:0] phase_d, phase_q;

  // Stall chain: a stage loads when empty or when its content moves on
  assign rdy1 = !v1_q || out_ready_i;
  assign rdy0 = !v0_q || rdy1;

  // Low 32 bits of the product and the start offset
  assign prod_d  = in_index_i * cfg_i.phase_step;
  assign phase_d = cfg_i.phase_start + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (rdy1 && v0_q) begin
      phase_q <= phase_d;
    end
  end

  assign in_ready_o  = rdy0;
  assign out_valid_o = v1_q;
  assign out_phase_o = phase_q;

endmodule

// ----- src/wsg_shape.sv -----
// ----------------------------------------------------------------------------
// wsg_shape: wave shaper front end
// Decodes the phase into a constant, a sine table entry or an edge division
// (numerator 2n+D, divisor 2D), and reads the sine table in a stage of its own.
// ----------------------------------------------------------------------------
module wsg_shape #(
  parameter int SineEntries = wsg_pkg::SINE_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsg_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wsg_pkg::PHASE_W-1:0]   in_phase_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsg_pkg::NUM_W-1:0]     out_num_o,
  output logic [wsg_pkg::DEN_W-1:0]     out_den_o,
  output wsg_pkg::side_t                out_side_o
);
  import wsg_pkg::*;

  localparam int SIdxW = $clog2(SineEntries);
  localparam int NW    = $clog2(SineEntries + 1);
  localparam int PW    = PHASE_W + NW;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One Taylor step: term * x^2 in Q30
  function automatic logic [63:0] sq_term(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t1;
    t1 = (term * x) >> 30;
    return (t1 * x) >> 30;
  endfunction

  // Table entry: quarter-wave reduction and Taylor series to x^15, Q1.15
  function automatic logic signed [Q15_W-1:0] sine_q15(input logic [PHASE_W-1:0] ph);
    logic [1:0]         quad;
    logic [63:0]        frac, t, x, sum, term, mag;
    logic signed [63:0] v;
    logic signed [Q15_W-1:0] r;
    quad   = ph[31:30];
    frac   = {34'd0, ph[29:0]};
    t      = quad[0] ? (Q30_ONE - frac) : frac;
    x      = (t * HALF_PI_Q30) >> 30;
    sum    = x;
    term   = sq_term(x, x) / 64'd6;
    sum    = (sum >= term) ? sum - term : 64'd0;
    term   = sq_term(term, x) / 64'd20;
    sum    = sum + term;
    term   = sq_term(term, x) / 64'd42;
    sum    = (sum >= term) ? sum - term : 64'd0;
    term   = sq_term(term, x) / 64'd72;
    sum    = sum + term;
    term   = sq_term(term, x) / 64'd110;
    sum    = (sum >= term) ? sum - term : 64'd0;
    term   = sq_term(term, x) / 64'd156;
    sum    = sum + term;
    term   = sq_term(term, x) / 64'd210;
    sum    = (sum >= term) ? sum - term : 64'd0;
    mag    = (sum * 64'd32768 + (Q30_ONE >> 1)) >> 30;
    v      = quad[1] ? -$signed(mag) : $signed(mag);
    if (v > 64'sd32767) begin
      r = Q15_MAX;
    end else if (v < -64'sd32768) begin
      r = Q15_MIN;
    end else begin
      r = v[Q15_W-1:0];
    end
    return r;
  endfunction

  // Constant sine table, one entry per phase step of the table
  logic signed [Q15_W-1:0] sine_rom [SineEntries];

  for (genvar k = 0; k < SineEntries; k++) begin : g_rom
    localparam logic [63:0] RomPhase = (64'(k) << 32) / 64'(SineEntries);
    assign sine_rom[k] = sine_q15(RomPhase[PHASE_W-1:0]);
  end

  logic                   v1_q, v2_q;
  logic                   rdy1, rdy2;
  logic [DEN_W-1:0]       ew, rr, ph_hi;
  logic [DEN_W:0]         de_sum;
  logic [17:0]            tri_s;
  logic signed [18:0]     tri_w;
  logic [PW-1:0]          sprod;
  logic [PHASE_W-1:0]     n_sel;
  logic [DEN_W-1:0]       d_sel;
  side_t                  side1_d, side1_q, side2_d, side2_q;
  logic [NUM_W-1:0]       num1_d, num1_q, num2_q;
  logic [DEN_W-1:0]       den1_q, den2_q;
  logic [SIdxW-1:0]       sidx_d, sidx_q;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;

  // Edge width of zero acts as one; ramp rise length is 65536 - width
  assign ew     = (cfg_i.edge_width == '0) ? 16'd1 : cfg_i.edge_width;
  assign rr     = 16'(17'h10000 - {1'b0, ew});
  assign ph_hi  = in_phase_i[PHASE_W-1:16];
  assign de_sum = {1'b0, cfg_i.duty_point} + {1'b0, ew};
  assign tri_s  = 18'(({1'b0, in_phase_i} + 33'd16384) >> 15);
  assign tri_w  = in_phase_i[PHASE_W-1] ? (19'sd98304 - $signed({1'b0, tri_s}))
                                        : ($signed({1'b0, tri_s}) - 19'sd32768);

  // Sine table index: floor(phase * entries / 2^32)
  assign sprod  = PW'(in_phase_i) * PW'(SineEntries);
  assign sidx_d = sprod[PHASE_W +: SIdxW];

  // Decode the shape at this phase
  always_comb begin
    side1_d = '{kind: KIND_CONST, neg: 1'b0, w: '0};
    n_sel   = '0;
    d_sel   = 16'd1;
    case (cfg_i.wave_shape)
      SHAPE_SINE: begin
        side1_d.kind = KIND_SINE;
      end
      SHAPE_SQUARE: begin
        if (ph_hi < ew) begin
          side1_d.kind = KIND_DIV;
          n_sel        = in_phase_i;
          d_sel        = ew;
        end else if (ph_hi < cfg_i.duty_point) begin
          side1_d.w = Q15_MAX;
        end else if ({1'b0, ph_hi} < de_sum) begin
          side1_d.kind = KIND_DIV;
          side1_d.neg  = 1'b1;
          n_sel        = in_phase_i - {cfg_i.duty_point, 16'h0};
          d_sel        = ew;
        end else begin
          side1_d.w = Q15_MIN;
        end
      end
      SHAPE_TRIANGLE: begin
        side1_d.w = sat_q15(tri_w);
      end
      SHAPE_RAMP: begin
        side1_d.kind = KIND_DIV;
        if (ph_hi < rr) begin
          n_sel = in_phase_i;
          d_sel = rr;
        end else begin
          side1_d.neg = 1'b1;
          n_sel       = in_phase_i - {rr, 16'h0};
          d_sel       = ew;
        end
      end
      default: begin
        side1_d.w = '0;
      end
    endcase
  end

  // Round-half-up numerator 2n + D
  assign num1_d = {1'b0, n_sel, 1'b0} + NUM_W'(d_sel);

  // Read the table for sine items
  always_comb begin
    side2_d = side1_q;
    if (side1_q.kind == KIND_SINE) begin
      side2_d.w = sine_rom[sidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      side1_q <= side1_d;
      num1_q  <= num1_d;
      den1_q  <= d_sel;
      sidx_q  <= sidx_d;
    end
    if (rdy2 && v1_q) begin
      side2_q <= side2_d;
      num2_q  <= num1_q;
      den2_q  <= den1_q;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;
  assign out_num_o   = num2_q;
  assign out_den_o   = den2_q;
  assign out_side_o  = side2_q;

`ifndef NO_ASSERTIONS
  // An edge division never sees a zero divisor
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && (side2_q.kind == KIND_DIV) |-> (den2_q != '0))
    else $error("edge divisor is zero");
`endif

endmodule

// ----- src/wsg_div.sv -----
// ----------------------------------------------------------------------------
// wsg_div: pipelined edge divider
// Restoring division floor(num / 2D), one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wsg_pkg::NUM_W-1:0]     in_num_i,
  input  logic [wsg_pkg::DEN_W-1:0]     in_den_i,
  input  wsg_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsg_pkg::QUOT_W-1:0]    out_quot_o,
  output wsg_pkg::side_t                out_side_o
);
  import wsg_pkg::*;

  localparam int Steps = QUOT_W;

  logic [Steps-1:0]   v_q;
  logic [Steps:0]     rdy;
  logic [QUOT_W-1:0]  rem_q  [Steps];
  logic [QUOT_W-1:0]  low_q  [Steps];
  logic [QUOT_W-1:0]  quot_q [Steps];
  logic [DEN_W-1:0]   den_q  [Steps];
  side_t              side_q [Steps];

  assign rdy[Steps] = out_ready_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;

    logic              prev_v;
    logic [QUOT_W-1:0] prev_rem, prev_low, prev_quot;
    logic [DEN_W-1:0]  prev_den;
    side_t             prev_side;
    logic [QUOT_W:0]   trial, den2;
    logic              ge;
    logic [QUOT_W-1:0] rem_d, quot_d;

    if (k == 0) begin : g_first
      // High part of the numerator seeds the remainder
      assign prev_v    = in_valid_i;
      assign prev_rem  = in_num_i[NUM_W-1:QUOT_W];
      assign prev_low  = in_num_i[QUOT_W-1:0];
      assign prev_quot = '0;
      assign prev_den  = in_den_i;
      assign prev_side = in_side_i;
    end else begin : g_next
      assign prev_v    = v_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_low  = low_q[k-1];
      assign prev_quot = quot_q[k-1];
      assign prev_den  = den_q[k-1];
      assign prev_side = side_q[k-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    assign trial = {prev_rem, prev_low[Bit]};
    assign den2  = {1'b0, prev_den, 1'b0};
    assign ge    = (trial >= den2);
    assign rem_d = ge ? QUOT_W'(trial - den2) : trial[QUOT_W-1:0];

    always_comb begin
      quot_d      = prev_quot;
      quot_d[Bit] = ge;
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && prev_v) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= prev_low;
        quot_q[k] <= quot_d;
        den_q[k]  <= prev_den;
        side_q[k] <= prev_side;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Steps-1];
  assign out_quot_o  = quot_q[Steps-1];
  assign out_side_o  = side_q[Steps-1];

`ifndef NO_ASSERTIONS
  // Final remainder stays below the divisor 2D
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Steps-1] |-> ({1'b0, rem_q[Steps-1]} < {1'b0, den_q[Steps-1], 1'b0}))
    else $error("divider remainder out of range");

  // Edge quotient never passes one full swing
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_side_o.kind == KIND_DIV) |-> (out_quot_o <= QUOT_MAX))
    else $error("edge quotient out of range");
`endif

endmodule

// ----- src/wsg_scale.sv -----
// ----------------------------------------------------------------------------
// wsg_scale: gain, offset and clamp
// Forms the wave value, multiplies by the gain, adds the offset around
// midscale, rounds half up and clamps to the code range.
// ----------------------------------------------------------------------------
module wsg_scale #(
  parameter int CountMax = wsg_pkg::COUNT_MAX
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsg_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wsg_pkg::QUOT_W-1:0]    in_quot_i,
  input  wsg_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsg_pkg::ADC_W-1:0]     out_adc_o
);
  import wsg_pkg::*;

  localparam int MidScale = (CountMax + 1) / 2;
  localparam int TW       = 37;
  localparam int CW       = TW - 15;

  logic                     v1_q, v2_q;
  logic                     rdy1, rdy2;
  logic signed [18:0]       wq;
  logic signed [Q15_W-1:0]  w_d;
  logic signed [32:0]       prod_d, prod_q;
  logic signed [18:0]       base;
  logic signed [TW-1:0]     t_sum;
  logic [CW-1:0]            c_raw;
  logic [ADC_W-1:0]         adc_d, adc_q;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;

  // Finish the edge value from the quotient
  assign wq = in_side_i.neg ? (19'sd32768 - $signed({2'b0, in_quot_i}))
                            : ($signed({2'b0, in_quot_i}) - 19'sd32768);

  always_comb begin
    if (in_side_i.kind == KIND_DIV) begin
      w_d = sat_q15(wq);
    end else begin
      w_d = in_side_i.w;
    end
  end

  assign prod_d = w_d * $signed({1'b0, cfg_i.gain_counts});

  // Midscale plus offset, in Q15 with the rounding half
  assign base  = 19'(MidScale) + 19'(cfg_i.offset_counts);
  assign t_sum = (TW'(base) <<< 15) + TW'(prod_q) + TW'(16384);
  assign c_raw = t_sum[TW-1:15];

  // Clamp to the code range
  always_comb begin
    if (t_sum[TW-1]) begin
      adc_d = '0;
    end else if (c_raw > CW'(CountMax)) begin
      adc_d = ADC_W'(CountMax);
    end else begin
      adc_d = c_raw[ADC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (rdy2 && v1_q) begin
      adc_q <= adc_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;
  assign out_adc_o   = adc_q;

`ifndef NO_ASSERTIONS
  // Delivered code never exceeds the clamp limit
  a_code_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (32'(adc_q) <= CountMax))
    else $error("sample code above clamp limit");
`endif

endmodule

// ----- src/waveform_sample_generator.sv -----
// Throughput: one sample per cycle unless stalled; the 17-stage edge divider
//   (one quotient bit per stage) sets the depth, and stalls collapse bubbles stage by stage.
// Reset clears all stage valid bits and loads the register defaults at once;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
// waveform_sample_generator: pipelined DDS sample generator
// Holds the configuration registers and chains phase, shaper, divider and
// scaler stages between the input and output streams.
// ----------------------------------------------------------------------------
module waveform_sample_generator #(
  parameter int SineEntries = wsg_pkg::SINE_ENTRIES,
  parameter int CountMax    = wsg_pkg::COUNT_MAX
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  wsg_in_if.sink                           in_i,
  wsg_out_if.source                        out_o
);
  import wsg_pkg::*;

  cfg_t                cfg_q;
  logic                ph_valid, ph_ready;
  logic [PHASE_W-1:0]  ph_phase;
  logic                sh_valid, sh_ready;
  logic [NUM_W-1:0]    sh_num;
  logic [DEN_W-1:0]    sh_den;
  side_t               sh_side;
  logic                dv_valid, dv_ready;
  logic [QUOT_W-1:0]   dv_quot;
  side_t               dv_side;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_shape    <= SHAPE_SINE;
      cfg_q.phase_step    <= '0;
      cfg_q.phase_start   <= '0;
      cfg_q.duty_point    <= 16'd32768;
      cfg_q.edge_width    <= 16'd1;
      cfg_q.gain_counts   <= 16'd512;
      cfg_q.offset_counts <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_SHAPE:    cfg_q.wave_shape    <= cfg_data_i[SHAPE_W-1:0];
        REG_PHASE_STEP:    cfg_q.phase_step    <= cfg_data_i[PHASE_W-1:0];
        REG_PHASE_START:   cfg_q.phase_start   <= cfg_data_i[PHASE_W-1:0];
        REG_DUTY_POINT:    cfg_q.duty_point    <= cfg_data_i[DEN_W-1:0];
        REG_EDGE_WIDTH:    cfg_q.edge_width    <= cfg_data_i[DEN_W-1:0];
        REG_GAIN_COUNTS:   cfg_q.gain_counts   <= cfg_data_i[DEN_W-1:0];
        REG_OFFSET_COUNTS: cfg_q.offset_counts <= $signed(cfg_data_i[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // Phase from sample index
  wsg_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_index_i  (in_i.sample_index),
    .out_valid_o (ph_valid),
    .out_ready_i (ph_ready),
    .out_phase_o (ph_phase)
  );

  // Shape decode and sine table
  wsg_shape #(
    .SineEntries (SineEntries)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (ph_valid),
    .in_ready_o  (ph_ready),
    .in_phase_i  (ph_phase),
    .out_valid_o (sh_valid),
    .out_ready_i (sh_ready),
    .out_num_o   (sh_num),
    .out_den_o   (sh_den),
    .out_side_o  (sh_side)
  );

  // Edge slope division
  wsg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sh_valid),
    .in_ready_o  (sh_ready),
    .in_num_i    (sh_num),
    .in_den_i    (sh_den),
    .in_side_i   (sh_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // Gain, offset, rounding and clamp; last stage is the output register
  wsg_scale #(
    .CountMax (CountMax)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_quot_i   (dv_quot),
    .in_side_i   (dv_side),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_adc_o   (out_o.adc_counts)
  );

endmodule
